/* src/msqd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package msqd_pkg;
   localparam int SERVERS_DEF      = 4;
   localparam int QUEUE_DEPTH_DEF  = 16;
   localparam int MAX_ARRIVALS_DEF = 15;
   localparam int LANES            = 4;
   localparam int TAG_COUNT        = 26;
   localparam int TICK_W           = 16;
   localparam int END_W            = 17;
   localparam int TAG_W            = 5;
   localparam int RAND_W           = 15;
   localparam int DUR_W            = 8;
   localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;

   // configuration register indexes
   localparam logic [2:0] CSR_SERVERS  = 3'd0;
   localparam logic [2:0] CSR_QLIMIT   = 3'd1;
   localparam logic [2:0] CSR_SMIN     = 3'd2;
   localparam logic [2:0] CSR_SMAX     = 3'd3;
   localparam logic [2:0] CSR_STOP     = 3'd4;

   // lane control from the sequencer
   typedef struct packed {
      logic                start;   // begin a duration computation
      logic [DUR_W-1:0]    smin;
      logic [DUR_W-1:0]    smax;
   } lane_ctl_type;
endpackage
`default_nettype wire

/* src/multi_server_queue_dispatcher.sv */
`timescale 1ns / 1ps
`default_nettype none
// Queue simulation stepper: each item is one tick. The lanes compute every
// server's service time in parallel in a bit-serial divider phase (no division
// when the range is empty), then arrivals enter the wait queue one per cycle, then
// servers are dispatched one per cycle in index order. One item is processed at a
// time; the result sits in an output register while the next item is taken. The
// user must see that configuration is written only while idle; the block does not enforce it.
module multi_server_queue_dispatcher #(
   parameter int SERVERS      = msqd_pkg::SERVERS_DEF,
   parameter int QUEUE_DEPTH  = msqd_pkg::QUEUE_DEPTH_DEF,
   parameter int MAX_ARRIVALS = msqd_pkg::MAX_ARRIVALS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write,
   input  wire logic [2:0]           csr_index,
   input  wire logic [15:0]          csr_data,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [3:0]           req_arrival_count,
   input  wire logic [14:0]          req_rand_lane0,
   input  wire logic [14:0]          req_rand_lane1,
   input  wire logic [14:0]          req_rand_lane2,
   input  wire logic [14:0]          req_rand_lane3,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [15:0]               rsp_tick_now,
   output logic [3:0]                rsp_busy_mask,
   output logic [4:0]                rsp_serving_tag0,
   output logic [4:0]                rsp_serving_tag1,
   output logic [4:0]                rsp_serving_tag2,
   output logic [4:0]                rsp_serving_tag3,
   output logic [4:0]                rsp_waiting_count,
   output logic [4:0]                rsp_head_tag,
   output logic [3:0]                rsp_rejected_count,
   output logic                      rsp_all_done
);
   import msqd_pkg::*;

   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = (SERVERS > 1) ? $clog2(SERVERS) : 1;
   localparam int AW = 4;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DIV   = 5'b00010,
      ST_ARR   = 5'b00100,
      ST_DISP  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   // configuration
   logic [2:0]        cfg_srv_ff;
   logic [4:0]        cfg_qlim_ff;
   logic [7:0]        cfg_smin_ff, cfg_smax_ff;
   logic [15:0]       cfg_stop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_srv_ff  <= 3'd4;
         cfg_qlim_ff <= 5'd16;
         cfg_smin_ff <= 8'd1;
         cfg_smax_ff <= 8'd10;
         cfg_stop_ff <= 16'd100;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SERVERS: cfg_srv_ff  <= csr_data[2:0];
            CSR_QLIMIT:  cfg_qlim_ff <= csr_data[4:0];
            CSR_SMIN:    cfg_smin_ff <= csr_data[7:0];
            CSR_SMAX:    cfg_smax_ff <= csr_data[7:0];
            CSR_STOP:    cfg_stop_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   logic [SW:0] active;
   logic [CW-1:0] limit;
   assign active = (32'(cfg_srv_ff) > SERVERS) ? (SW+1)'(SERVERS) : (SW+1)'(cfg_srv_ff);
   assign limit  = (32'(cfg_qlim_ff) > QUEUE_DEPTH) ? CW'(QUEUE_DEPTH) : CW'(cfg_qlim_ff);

   // state
   state_type             st_ff, st_in;
   logic [TICK_W-1:0]     tick_ff;
   logic [SERVERS-1:0]    busy_ff;
   logic [END_W-1:0]      end_ff [SERVERS];
   logic [TAG_W-1:0]      stag_ff [SERVERS];
   logic [TAG_W-1:0]      fifo_mem [QUEUE_DEPTH];
   logic [QW-1:0]         head_ff;
   logic [CW-1:0]         count_ff;
   logic [TAG_W-1:0]      tag_ff;
   logic [AW-1:0]         arr_ff;
   logic [AW-1:0]         rej_ff;
   logic [SW:0]           srv_ff;
   logic [TAG_W-1:0]      head_rd;

   // output register
   logic                  ov_ff, ov_in;
   logic [15:0]           o_tick_ff;
   logic [3:0]            o_mask_ff, o_rej_ff;
   logic [4:0]            o_tag_ff [4];
   logic [4:0]            o_cnt_ff, o_head_ff;
   logic                  o_done_ff;

   // lanes
   lane_ctl_type          lctl;
   logic [DUR_W-1:0]      ldur [SERVERS];
   logic [SERVERS-1:0]    lbusy;

   assign lctl.start = (st_ff == ST_IDLE) && req_valid && !req_stall;
   assign lctl.smin  = cfg_smin_ff;
   assign lctl.smax  = cfg_smax_ff;

   for (genvar g = 0; g < SERVERS; g++) begin : g_lane
      logic [RAND_W-1:0] rsel;
      always_comb begin
         case (g % LANES)
            0: rsel = req_rand_lane0;
            1: rsel = req_rand_lane1;
            2: rsel = req_rand_lane2;
            default: rsel = req_rand_lane3;
         endcase
      end
      msqd_lane u_lane (
         .clock(clock), .reset(reset), .ctl(lctl),
         .rand_word(rsel), .dur(ldur[g]), .busy(lbusy[g])
      );
   end

   assign req_stall = (st_ff != ST_IDLE);

   logic [AW-1:0] arr_clip;
   assign arr_clip = (32'(req_arrival_count) > MAX_ARRIVALS) ? AW'(MAX_ARRIVALS)
                                                             : req_arrival_count;

   // tail slot, wrapped by one compare and subtract
   logic [CW:0]   tail_sum;
   logic [QW-1:0] tail_idx;
   assign tail_sum = (CW+1)'(head_ff) + (CW+1)'(count_ff);
   assign tail_idx = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                     QW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : QW'(tail_sum);
   assign head_rd  = fifo_mem[head_ff];

   logic [SW-1:0] srv_idx;
   assign srv_idx = srv_ff[SW-1:0];

   // sequencer
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (req_valid) st_in = ST_DIV;
         ST_DIV:  if (lbusy == '0) st_in = ST_ARR;
         ST_ARR:  if (arr_ff == '0 || tick_ff >= cfg_stop_ff) st_in = ST_DISP;
         ST_DISP: if (srv_ff >= active) st_in = ST_OUT;
         ST_OUT:  if (!ov_ff || !rsp_stall) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // result valid: cleared when taken, set when a new result is loaded
   always_comb begin
      ov_in = ov_ff;
      if (ov_ff && !rsp_stall) ov_in = 1'b0;
      if (st_ff == ST_OUT && (!ov_ff || !rsp_stall)) ov_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         tick_ff  <= '0;
         busy_ff  <= '0;
         head_ff  <= '0;
         count_ff <= '0;
         tag_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
         case (st_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  arr_ff <= arr_clip;
                  rej_ff <= '0;
                  srv_ff <= '0;
                  // release finished and inactive servers
                  for (int i = 0; i < SERVERS; i++) begin
                     if ((SW+1)'(i) >= active) busy_ff[i] <= 1'b0;
                     else if (end_ff[i] <= END_W'(tick_ff)) busy_ff[i] <= 1'b0;
                  end
               end
            end
            ST_ARR: begin
               // one arrival per cycle
               if (arr_ff != '0 && tick_ff < cfg_stop_ff) begin
                  arr_ff <= arr_ff - 1'b1;
                  if (count_ff < limit) begin
                     count_ff <= count_ff + 1'b1;
                     tag_ff <= (32'(tag_ff) + 1 >= TAG_COUNT) ? '0 : tag_ff + 1'b1;
                  end else begin
                     rej_ff <= rej_ff + 1'b1;
                  end
               end
            end
            ST_DISP: begin
               // one server per cycle, index order
               if (srv_ff < active) begin
                  srv_ff <= srv_ff + 1'b1;
                  if (!busy_ff[srv_idx] && count_ff != '0) begin
                     busy_ff[srv_idx] <= 1'b1;
                     head_ff  <= (32'(head_ff) == QUEUE_DEPTH - 1) ? '0 : head_ff + 1'b1;
                     count_ff <= count_ff - 1'b1;
                  end
               end
            end
            ST_OUT: begin
               if (!ov_ff || !rsp_stall) begin
                  if (tick_ff != TICK_MAX) tick_ff <= tick_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (st_ff == ST_ARR && arr_ff != '0 && tick_ff < cfg_stop_ff && count_ff < limit)
         fifo_mem[tail_idx] <= tag_ff;
      if (st_ff == ST_DISP && srv_ff < active && !busy_ff[srv_idx] && count_ff != '0) begin
         stag_ff[srv_idx] <= head_rd;
         end_ff[srv_idx]  <= END_W'(tick_ff) + END_W'(ldur[srv_idx]);
      end
   end

   // result capture
   always_ff @(posedge clock) begin
      if (st_ff == ST_OUT && (!ov_ff || !rsp_stall)) begin
         o_tick_ff <= tick_ff;
         o_cnt_ff  <= 5'(count_ff);
         o_head_ff <= (count_ff != '0) ? head_rd : '0;
         o_rej_ff  <= rej_ff;
         o_done_ff <= (busy_ff == '0) && (tick_ff >= cfg_stop_ff);
         for (int i = 0; i < 4; i++) begin
            if (i < SERVERS) begin
               o_mask_ff[i] <= busy_ff[i];
               o_tag_ff[i]  <= busy_ff[i] ? stag_ff[i] : '0;
            end else begin
               o_mask_ff[i] <= 1'b0;
               o_tag_ff[i]  <= '0;
            end
         end
      end
   end

   assign rsp_valid          = ov_ff;
   assign rsp_tick_now       = o_tick_ff;
   assign rsp_busy_mask      = o_mask_ff;
   assign rsp_serving_tag0   = o_tag_ff[0];
   assign rsp_serving_tag1   = o_tag_ff[1];
   assign rsp_serving_tag2   = o_tag_ff[2];
   assign rsp_serving_tag3   = o_tag_ff[3];
   assign rsp_waiting_count  = o_cnt_ff;
   assign rsp_head_tag       = o_head_ff;
   assign rsp_rejected_count = o_rej_ff;
   assign rsp_all_done       = o_done_ff;
endmodule
`default_nettype wire

/* src/msqd_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// one server lane: computes min + rand % (max - min) by restoring division,
// one quotient bit a cycle
module msqd_lane (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire msqd_pkg::lane_ctl_type        ctl,
   input  wire logic [msqd_pkg::RAND_W-1:0]   rand_word,
   output logic [msqd_pkg::DUR_W-1:0]         dur,
   output logic                               busy
);
   import msqd_pkg::*;

   logic [DUR_W:0]              rem_ff, rem_in;
   logic [RAND_W-1:0]           sh_ff, sh_in;
   logic [DUR_W-1:0]            div_ff, div_in;
   logic [DUR_W-1:0]            base_ff, base_in;
   logic [$clog2(RAND_W+1)-1:0] cnt_ff, cnt_in;
   logic                        run_ff, run_in;
   logic [DUR_W:0]              trial;

   always_comb begin
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      div_in  = div_ff;
      base_in = base_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      trial   = {rem_ff[DUR_W-1:0], sh_ff[RAND_W-1]};
      if (ctl.start) begin
         rem_in  = '0;
         sh_in   = rand_word;
         base_in = ctl.smin;
         if (ctl.smax > ctl.smin) begin
            div_in = ctl.smax - ctl.smin;
            cnt_in = ($clog2(RAND_W+1))'(RAND_W);
            run_in = 1'b1;
         end else begin
            div_in = '0;
            cnt_in = '0;
            run_in = 1'b0;
         end
      end else if (run_ff) begin
         // shift in one dividend bit, subtract when it fits
         sh_in = {sh_ff[RAND_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) rem_in = trial - {1'b0, div_ff};
         else rem_in = trial;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ($clog2(RAND_W+1))'(1)) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
      div_ff  <= div_in;
      base_ff <= base_in;
   end

   // sum is below 256 as rem < max - min
   assign dur  = base_ff + rem_ff[DUR_W-1:0];
   assign busy = run_ff;
endmodule
`default_nettype wire

/* src/msqd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module msqd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_tick_now,
   input wire logic [3:0]  rsp_busy_mask,
   input wire logic [4:0]  rsp_waiting_count,
   input wire logic        rsp_all_done
);
   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tick_now))
      else $error("stalled item changed");
   // done means no server busy
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_all_done |-> rsp_busy_mask == 4'd0)
      else $error("done with busy server");
   // queue never exceeds its depth
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_waiting_count <= 5'd16)
      else $error("queue count out of range");
   // an accepted item is followed by no other accept in the next cycle
   a_seq: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken too early");
endmodule

bind multi_server_queue_dispatcher msqd_checker u_msqd_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_tick_now(rsp_tick_now),
   .rsp_busy_mask(rsp_busy_mask), .rsp_waiting_count(rsp_waiting_count),
   .rsp_all_done(rsp_all_done)
);
`default_nettype wire
